// ----- src/ddq_pkg.sv -----
// Shared types and codes for the deduplicating download-target queue.
// Used by ddq_entry_ram and dedup_download_target_queue; no dependencies.
`default_nettype none
package ddq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_REMOVED = 3'd5
  } status_t;

  // Laid out so that the lowest field is the address, matching the beat layout
  typedef struct packed {
    logic [63:0] h3;
    logic [63:0] h2;
    logic [63:0] h1;
    logic [63:0] h0;
    logic [15:0] port;
    logic [31:0] ipv4;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- src/dedup_download_target_queue.sv -----
// Deduplicating download-target queue: push with duplicate scan, pop with shift, remove by hash.
// An op on an empty list goes straight to the result without reading the store; otherwise the
// scan visits the held entries, and a push stops at the entry where it finds a duplicate.
// Throughput: one op at a time; the scan reads one entry per cycle from the single read port.
// A new op is taken only when idle, so a result beat that waits holds off the next op.
// Reset: synchronous, active low; list emptied, no result pending. Entry store is not cleared.
// Depends on ddq_pkg and ddq_entry_ram.
`default_nettype none
module dedup_download_target_queue #(
  parameter int unsigned DEPTH = ddq_pkg::DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // ipv4[31:0], port[47:32], hash_w0[111:48], hash_w1[175:112], hash_w2[239:176],
  // hash_w3[303:240]
  input  wire [303:0]  in_tdata,
  // operation[1:0]
  input  wire [1:0]    in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // head_ipv4[31:0], head_port[47:32], head_hash_w0..w3[303:48], removed_count[308:304],
  // entries_held[313:309], zero[319:314]
  output logic [319:0] out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser
);
  import ddq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  entry_t            key_r, key_nxt;
  entry_t            head_r, head_nxt;
  status_t           res_r, res_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              wb_r, wb_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  entry_t            out_head_r, out_head_nxt;
  logic [4:0]        out_rem_r, out_rem_nxt;
  logic [4:0]        out_held_r, out_held_nxt;

  logic              wr_en, rd_en;
  logic [IW-1:0]     wr_addr, rd_addr;
  entry_t            wr_data, rd_data;

  logic              in_acc;
  logic              last;
  logic              hash_hit, full_hit;
  logic [CW-1:0]     cnt_dec;

  ddq_entry_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign last      = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign cnt_dec   = cnt_r - CW'(1);
  assign hash_hit  = (rd_data.h0 == key_r.h0) && (rd_data.h1 == key_r.h1) &&
                     (rd_data.h2 == key_r.h2) && (rd_data.h3 == key_r.h3);
  assign full_hit  = hash_hit && (rd_data.ipv4 == key_r.ipv4) &&
                     (rd_data.port == key_r.port);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    head_nxt       = head_r;
    res_nxt        = res_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    idx_nxt        = idx_r;
    wb_nxt         = wb_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_head_nxt   = out_head_r;
    out_rem_nxt    = out_rem_r;
    out_held_nxt   = out_held_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = op_t'(in_tuser);
          key_nxt  = entry_t'(in_tdata);
          head_nxt = '0;
          rem_nxt  = '0;
          idx_nxt  = '0;
          wb_nxt   = 1'b0;
          if (cnt_r == '0) begin
            state_nxt = S_DONE;
            unique case (in_tuser)
              OP_PUSH: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = entry_t'(in_tdata);
                cnt_nxt = CW'(1);
                res_nxt = ST_PUSHED;
              end
              OP_REMOVE: res_nxt = ST_REMOVED;
              default:   res_nxt = ST_EMPTY;
            endcase
          end else if (in_tuser == OP_PUSH || in_tuser == OP_POP ||
                       in_tuser == OP_REMOVE) begin
            rd_en     = 1'b1;
            state_nxt = S_EV;
          end else begin
            res_nxt   = ST_EMPTY;
            state_nxt = S_DONE;
          end
        end
      end

      // rd_data holds the entry at idx_r
      S_EV: begin
        case (op_r)
          OP_PUSH: begin
            if (full_hit) begin
              res_nxt   = ST_DUP;
              state_nxt = S_DONE;
            end else if (last) begin
              state_nxt = S_DONE;
              if (cnt_r == CW'(DEPTH)) begin
                res_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = IW'(cnt_r);
                wr_data = key_r;
                cnt_nxt = cnt_r + CW'(1);
                res_nxt = ST_PUSHED;
              end
            end else begin
              idx_nxt = idx_r + IW'(1);
              rd_en   = 1'b1;
              rd_addr = idx_r + IW'(1);
            end
          end

          OP_POP: begin
            if (idx_r == '0) begin
              head_nxt = rd_data;
            end else begin
              wr_en   = 1'b1;
              wr_addr = idx_r - IW'(1);
            end
            if (last) begin
              cnt_nxt   = cnt_dec;
              res_nxt   = ST_POPPED;
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idx_r + IW'(1);
              rd_en   = 1'b1;
              rd_addr = idx_r + IW'(1);
            end
          end

          default: begin
            // remove: a moved-in last entry is written back and checked again
            wr_en = wb_r;
            if (hash_hit) begin
              cnt_nxt = cnt_dec;
              rem_nxt = rem_r + CW'(1);
              if (CW'(idx_r) == cnt_dec) begin
                res_nxt   = ST_REMOVED;
                state_nxt = S_DONE;
              end else begin
                wb_nxt  = 1'b1;
                rd_en   = 1'b1;
                rd_addr = IW'(cnt_dec);
              end
            end else begin
              wb_nxt = 1'b0;
              if (last) begin
                res_nxt   = ST_REMOVED;
                state_nxt = S_DONE;
              end else begin
                idx_nxt = idx_r + IW'(1);
                rd_en   = 1'b1;
                rd_addr = idx_r + IW'(1);
              end
            end
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_head_nxt   = head_r;
          out_rem_nxt    = 5'(rem_r);
          out_held_nxt   = 5'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      wb_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      wb_r        <= wb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    head_r       <= head_nxt;
    res_r        <= res_nxt;
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_head_r   <= out_head_nxt;
    out_rem_r    <= out_rem_nxt;
    out_held_r   <= out_held_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_held_r, out_rem_r, out_head_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EV |-> CW'(idx_r) < cnt_r)
    else $error("scan index outside the held entries");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> CW'(wr_addr) < CW'(DEPTH))
    else $error("store write beyond depth");

  a_cnt_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> cnt_r == $past(cnt_r))
    else $error("entry count moved while result waits");

endmodule
`default_nettype wire

// ----- src/ddq_entry_ram.sv -----
// Entry store: one write port, one read port, registered read data.
// Depends on ddq_pkg for the entry layout.
`default_nettype none
module ddq_entry_ram #(
  parameter int unsigned DEPTH = ddq_pkg::DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire ddq_pkg::entry_t      wr_data,
  input  wire                       rd_en,
  input  wire [$clog2(DEPTH)-1:0]   rd_addr,
  output ddq_pkg::entry_t           rd_data
);
  import ddq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- dv/tb_dedup_download_target_queue.sv -----
// Self-checking testbench for dedup_download_target_queue: push, pop, remove and the unused code,
// checked beat by beat against a predictor of the list held in the bench.
// Depends on ddq_pkg and the RTL of the queue only.
`default_nettype none
module tb_dedup_download_target_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import ddq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    status_t     status;
    entry_t      head;
    logic [4:0]  removed;
    logic [4:0]  held;
  } queue_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [303:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [319:0] out_tdata;
  logic [2:0]   out_tuser;

  // predicted list contents
  entry_t        held_list [DEPTH];
  int unsigned   held_total = 0;
  queue_result_t expected_results [$];

  int unsigned   err_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  logic          hold_on = 1'b0;
  int unsigned   hold_cnt = 0;
  int unsigned   idle_cycles = 0;
  queue_result_t want;
  entry_t        got_head;

  dedup_download_target_queue #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic queue_result_t queue_apply(input logic [1:0] op_code, input entry_t item);
    queue_result_t res;
    int unsigned   idx;
    bit            found;
    res = '0;
    res.status = ST_EMPTY;
    found = 1'b0;
    case (op_code)
      OP_PUSH: begin
        for (idx = 0; idx < held_total; idx++)
          if (held_list[idx] == item) found = 1'b1;
        if (found) begin
          res.status = ST_DUP;
        end else if (held_total >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_list[held_total] = item;
          held_total++;
          res.status = ST_PUSHED;
        end
      end
      OP_POP: begin
        if (held_total != 0) begin
          res.head = held_list[0];
          for (idx = 0; idx + 1 < held_total; idx++) held_list[idx] = held_list[idx + 1];
          held_total--;
          res.status = ST_POPPED;
        end
      end
      OP_REMOVE: begin
        // a hit is replaced by the last entry and the same slot is looked at again
        idx = 0;
        while (idx < held_total) begin
          if (held_list[idx][303:48] == item[303:48]) begin
            held_total--;
            held_list[idx] = held_list[held_total];
            res.removed++;
          end else begin
            idx++;
          end
        end
        res.status = ST_REMOVED;
      end
      default: ;
    endcase
    res.held = held_total[4:0];
    return res;
  endfunction

  function automatic entry_t make_entry(input logic [31:0] ipv4, input logic [15:0] port,
                                        input logic [255:0] hash);
    entry_t e;
    e.ipv4 = ipv4;
    e.port = port;
    e.h0 = hash[63:0];
    e.h1 = hash[127:64];
    e.h2 = hash[191:128];
    e.h3 = hash[255:192];
    return e;
  endfunction

  function automatic entry_t random_entry();
    logic [319:0] bits;
    for (int k = 0; k < 10; k++) bits[k*32 +: 32] = $urandom;
    return bits[303:0];
  endfunction

  // small pool so that duplicates and multi-entry removes turn up often
  function automatic logic [255:0] pool_hash(input int unsigned k);
    logic [255:0] base;
    base = {64'h4444_3333_2222_1111, 64'h8888_7777_6666_5555,
            64'hCCCC_BBBB_AAAA_9999, 64'h0123_4567_89AB_CDEF};
    if (k == 0) return '1;
    if (k == 1) return '0;
    return base ^ (256'd1 << (64 * ((k - 2) % 4) + k));
  endfunction

  function automatic entry_t pool_entry();
    logic [31:0] ipv4;
    logic [15:0] port;
    case ($urandom_range(3))
      0: begin ipv4 = '0; port = '0; end
      1: begin ipv4 = '1; port = '1; end
      2: begin ipv4 = 32'h0A00_0001; port = 16'd8080; end
      default: begin ipv4 = 32'hC0A8_0101; port = 16'd443; end
    endcase
    return make_entry(ipv4, port, pool_hash($urandom_range(6)));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want_v);
    // keep the log bounded if the block is badly broken
    if (err_count < 100)
      $display("%0t ns MISMATCH %s: got %0h, expected %0h", $time, what, got, want_v);
    err_count++;
  endtask

  task automatic send_op(input logic [1:0] op_code, input entry_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    in_tuser  <= op_code;
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_results.push_back(queue_apply(op_code, item));
  endtask

  task automatic settle_queue();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_op(OP_POP, random_entry());
    send_op(OP_UNUSED, random_entry());
    send_op(OP_REMOVE, random_entry());
  endtask

  task automatic test_fill_to_full();
    logic [255:0] shared_hash;
    shared_hash = pool_hash(3);
    send_op(OP_PUSH, make_entry('1, '1, '1));
    send_op(OP_PUSH, make_entry('0, '0, '0));
    // even slots share one hash, odd slots each get their own
    for (int unsigned k = 2; k < DEPTH; k++)
      send_op(OP_PUSH, make_entry(32'h0A00_0000 + k, 16'(1000 + k),
                                  (k % 2 == 0) ? shared_hash : shared_hash ^ 256'(k)));
    send_op(OP_PUSH, make_entry(32'hC0A8_0001, 16'd1, shared_hash));
    send_op(OP_PUSH, make_entry(32'h0A00_0005, 16'd1005, shared_hash ^ 256'd5));
    send_op(OP_UNUSED, random_entry());
    send_op(OP_REMOVE, make_entry('0, '0, shared_hash));
    send_op(OP_POP, random_entry());
    settle_queue();
  endtask

  task automatic run_mixed_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    int unsigned push_weight;
    int unsigned r;
    logic [1:0]  op_code;
    entry_t      item;
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    push_weight = 55;
    for (int unsigned n = 0; n < n_items; n++) begin
      // shift the op mix now and then so the list swings between empty and full
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: push_weight = 85;
          1: push_weight = 55;
          default: push_weight = 25;
        endcase
      end
      item = random_entry();
      if ($urandom_range(99) < 3) begin
        op_code = OP_UNUSED;
      end else if ($urandom_range(99) < push_weight) begin
        op_code = OP_PUSH;
        r = $urandom_range(9);
        if (r >= 2) item = pool_entry();
        if (r >= 2 && r <= 4 && held_total != 0) item = held_list[$urandom_range(held_total - 1)];
      end else if ($urandom_range(2) != 0) begin
        op_code = OP_POP;
      end else begin
        op_code = OP_REMOVE;
        r = $urandom_range(9);
        if (r >= 1) item = pool_entry();
        if (r >= 1 && r <= 5 && held_total != 0) item = held_list[$urandom_range(held_total - 1)];
      end
      send_op(op_code, item);
    end
    settle_queue();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_on <= 1'b1;
    for (int unsigned n = 0; n < 30; n++)
      send_op((n % 3 == 2) ? OP_POP : OP_PUSH, pool_entry());
    settle_queue();
    hold_on <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_on && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_on) hold_cnt <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected, status", out_tuser, '0);
      end else begin
        want = expected_results.pop_front();
        got_head = out_tdata[303:0];
        if (out_tuser !== want.status) report_mismatch("status", out_tuser, want.status);
        if (got_head.ipv4 !== want.head.ipv4)
          report_mismatch("head_ipv4", got_head.ipv4, want.head.ipv4);
        if (got_head.port !== want.head.port)
          report_mismatch("head_port", got_head.port, want.head.port);
        if (got_head.h0 !== want.head.h0) report_mismatch("head_hash_w0", got_head.h0, want.head.h0);
        if (got_head.h1 !== want.head.h1) report_mismatch("head_hash_w1", got_head.h1, want.head.h1);
        if (got_head.h2 !== want.head.h2) report_mismatch("head_hash_w2", got_head.h2, want.head.h2);
        if (got_head.h3 !== want.head.h3) report_mismatch("head_hash_w3", got_head.h3, want.head.h3);
        if (out_tdata[308:304] !== want.removed)
          report_mismatch("removed_count", out_tdata[308:304], want.removed);
        if (out_tdata[313:309] !== want.held)
          report_mismatch("entries_held", out_tdata[313:309], want.held);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_dedup_download_target_queue failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_to_full();
    run_mixed_traffic(460, 0, 0);
    run_mixed_traffic(460, 45, 0);
    run_mixed_traffic(460, 0, 45);
    run_mixed_traffic(460, 31, 31);
    test_backpressure();
    repeat (DEPTH + 4) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("tb_dedup_download_target_queue passed");
    end else begin
      $display("tb_dedup_download_target_queue failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
src/ddq_pkg.sv
src/ddq_entry_ram.sv
src/dedup_download_target_queue.sv
dv/tb_dedup_download_target_queue.sv
